@@ rtl/las_pkg.sv @@
// Shared types and constants for the local alignment score block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package las_pkg;

	localparam int MAX_QUERY_DEF = 64;

	localparam int BASE_W     = 2;
	localparam int SCORE_W    = 10;
	localparam int SUM_W      = 12;  // signed headroom for score + bonus or penalty
	localparam int MATCH_W    = 4;
	localparam int PEN_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	localparam logic [MATCH_W-1:0] MATCH_BONUS_RST    = 4'd3;
	localparam logic [PEN_W-1:0]   MISMATCH_SCORE_RST = 5'b11101;  // -3
	localparam logic [PEN_W-1:0]   GAP_SCORE_RST      = 5'b11110;  // -2

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_BONUS    = 2'd0,
		REG_MISMATCH_SCORE = 2'd1,
		REG_GAP_SCORE      = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [MATCH_W-1:0] match_bonus;
		logic [PEN_W-1:0]   mismatch_score;  // two's complement
		logic [PEN_W-1:0]   gap_score;       // two's complement
	} cfg_t;

	// Wavefront token handed from one cell to the next.
	typedef struct packed {
		logic               valid;
		logic [BASE_W-1:0]  base;
		logic               last;
		logic [SCORE_W-1:0] h;     // new score of the sending cell
		logic [SCORE_W-1:0] diag;  // old score of the sending cell
		logic [SCORE_W-1:0] best;  // running max along the column
	} wave_t;

endpackage

@@ rtl/las_if.sv @@
// Channel interfaces of the local alignment score block: input items and results.
// Depends on las_pkg for field widths.
`timescale 1ns / 1ps

interface las_item_if import las_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [BASE_W-1:0] base;
	logic              last;

	modport source(output valid, output req_type, output base, output last, input ready);
	modport sink(input valid, input req_type, input base, input last, output ready);
endinterface

interface las_result_if import las_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] align_score;

	modport source(output valid, output align_score, input ready);
	modport sink(input valid, input align_score, output ready);
endinterface

@@ rtl/local_alignment_score.sv @@
// Smith-Waterman local alignment score, linear gap cost: systolic cell chain.
// Depends on las_pkg, las_if (las_item_if, las_result_if) and las_cell.
//
// Use: query bases (req_type 0) are loaded first, one beat each, up to
// MAX_QUERY; further bases are dropped. Subject bases (req_type 1) follow,
// one beat per cycle unless the chain is frozen. Each subject beat moves
// down a chain of MAX_QUERY cells, one cell per cycle while it is not frozen;
// cell i scores it against query base i. The beat marked last passes the
// MAX_QUERY cell registers to the chain end, and its best score is then
// registered into the result register as it leaves the chain.
// Subject beats go in at one per cycle, set by the chain advancing one cell
// per cycle, while it is not frozen. A query beat waits until the chain
// holds no subject beat, so after a subject it waits for the chain to drain.
// Configuration (cfg_wr_en/cfg_index/cfg_wdata) is to be written only while idle; the block does not enforce it.
// Reset clears the query length, the column scores, the best score and the
// result valid flag; the result score and the query base store hold garbage
// until written. If the receiver stalls while a result is held and another
// finished subject reaches the chain end, the whole chain freezes until the
// held result is taken; no input beat is accepted meanwhile.
`timescale 1ns / 1ps

module local_alignment_score import las_pkg::*; #(
	parameter int MAX_QUERY = MAX_QUERY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	las_item_if.sink              item,
	las_result_if.source          result
);

	localparam int LEN_W = $clog2(MAX_QUERY + 1);

	// configuration
	cfg_t cfg_q;

	// query bookkeeping
	logic [LEN_W-1:0] qlen_q;
	logic             qdone_q;

	// subject beats inside the chain
	logic [LEN_W-1:0] inflight_q;

	// best score of the current subject, result register
	logic [SCORE_W-1:0] best_acc_q;
	logic               out_v_q;
	logic [SCORE_W-1:0] out_score_q;

	wave_t wave [MAX_QUERY+1];
	wave_t exit_w;

	logic               adv, acc, ld, sub, clr, exit_take;
	logic [LEN_W-1:0]   wr_idx;
	logic               wr_ok;
	logic [SCORE_W-1:0] best_final;

	assign exit_w = wave[MAX_QUERY];

	// the chain only halts when a finished subject cannot hand off its result
	assign adv = !(exit_w.valid && exit_w.last && out_v_q && !result.ready);

	// query beats need an empty chain; subject beats flow right behind each other
	assign item.ready = adv && (item.req_type || inflight_q == '0);

	assign acc = item.valid && item.ready;
	assign ld  = acc && !item.req_type;
	assign sub = acc && item.req_type;

	// a query beat after a finished query starts a new one and wipes the scores
	assign clr    = ld && qdone_q;
	assign wr_idx = qdone_q ? '0 : qlen_q;
	assign wr_ok  = qdone_q || (qlen_q < LEN_W'(MAX_QUERY));

	assign exit_take  = exit_w.valid && adv;
	assign best_final = (exit_w.best > best_acc_q) ? exit_w.best : best_acc_q;

	// head of the chain: nothing above the first query row
	always_comb begin
		wave[0]       = '0;
		wave[0].valid = sub;
		wave[0].base  = item.base;
		wave[0].last  = item.last;
	end

	for (genvar g = 0; g < MAX_QUERY; g++) begin : g_cell
		localparam logic [LEN_W-1:0] IDX = LEN_W'(g);

		las_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.clr       (clr),
			.load_en   (ld && wr_ok && wr_idx == IDX),
			.load_base (item.base),
			.active    (IDX < qlen_q),
			.cfg       (cfg_q),
			.prev      (wave[g]),
			.next      (wave[g+1])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_bonus    <= MATCH_BONUS_RST;
			cfg_q.mismatch_score <= MISMATCH_SCORE_RST;
			cfg_q.gap_score      <= GAP_SCORE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_MATCH_BONUS:    cfg_q.match_bonus    <= cfg_wdata[MATCH_W-1:0];
				REG_MISMATCH_SCORE: cfg_q.mismatch_score <= cfg_wdata[PEN_W-1:0];
				REG_GAP_SCORE:      cfg_q.gap_score      <= cfg_wdata[PEN_W-1:0];
				default: ;
			endcase
		end
	end

	// query length, completion flag, beat count in the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q     <= '0;
			qdone_q    <= 1'b0;
			inflight_q <= '0;
		end else begin
			if (ld) begin
				if (wr_ok) begin
					qlen_q <= wr_idx + LEN_W'(1);
				end else begin
					qlen_q <= wr_idx;
				end
				qdone_q <= item.last;
			end else if (sub) begin
				qdone_q <= 1'b1;
			end
			if (sub && !exit_take) begin
				inflight_q <= inflight_q + LEN_W'(1);
			end else if (!sub && exit_take) begin
				inflight_q <= inflight_q - LEN_W'(1);
			end
		end
	end

	// best score across subject beats, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_acc_q <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (clr) begin
				best_acc_q <= '0;
			end else if (exit_take) begin
				best_acc_q <= exit_w.last ? '0 : best_final;
			end
			if (exit_take && exit_w.last) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_take && exit_w.last) begin
			out_score_q <= best_final;
		end
	end

	assign result.valid       = out_v_q;
	assign result.align_score = out_score_q;

	// a query beat never lands on a busy chain
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> inflight_q == '0)
		else $error("query beat accepted with subject beats in flight");

	// the beat count stays within the number of cells
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= LEN_W'(MAX_QUERY))
		else $error("subject beat count exceeds chain length");

	// the query length never passes the store depth
	a_qlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qlen_q <= LEN_W'(MAX_QUERY))
		else $error("query length above store depth");

	// a new result only comes from a last beat leaving the chain
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(exit_w.valid && exit_w.last && adv))
		else $error("result raised without a finished subject");

	// a frozen chain keeps its tail beat
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(exit_w))
		else $error("tail beat changed while chain halted");

endmodule

@@ rtl/las_cell.sv @@
// One systolic cell: holds one query base and its column score, scores the
// passing subject base. Depends on las_pkg.
`timescale 1ns / 1ps

module las_cell import las_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              clr,
	input  logic              load_en,
	input  logic [BASE_W-1:0] load_base,
	input  logic              active,
	input  cfg_t              cfg,
	input  wave_t             prev,
	output wave_t             next
);

	logic [BASE_W-1:0]  qbase_q;
	logic [SCORE_W-1:0] score_q;
	wave_t              next_q;

	logic signed [SUM_W-1:0] sub_s, gap_s, c_diag, c_up, c_left, m0, m1, m2;
	logic [SCORE_W-1:0]      h, best_n;

	always_comb begin
		if (qbase_q == prev.base) begin
			sub_s = $signed({{(SUM_W-MATCH_W){1'b0}}, cfg.match_bonus});
		end else begin
			sub_s = $signed({{(SUM_W-PEN_W){cfg.mismatch_score[PEN_W-1]}}, cfg.mismatch_score});
		end
		gap_s  = $signed({{(SUM_W-PEN_W){cfg.gap_score[PEN_W-1]}}, cfg.gap_score});
		c_diag = $signed({{(SUM_W-SCORE_W){1'b0}}, prev.diag}) + sub_s;
		c_up   = $signed({{(SUM_W-SCORE_W){1'b0}}, prev.h}) + gap_s;
		c_left = $signed({{(SUM_W-SCORE_W){1'b0}}, score_q}) + gap_s;
		m0 = (c_diag > 0) ? c_diag : '0;
		m1 = (c_up > m0) ? c_up : m0;
		m2 = (c_left > m1) ? c_left : m1;
		// saturate at the top of the score range
		if (m2 > $signed({{(SUM_W-SCORE_W){1'b0}}, SCORE_MAX})) begin
			h = SCORE_MAX;
		end else begin
			h = m2[SCORE_W-1:0];
		end
		best_n = (active && h > prev.best) ? h : prev.best;
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			qbase_q <= load_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			next_q  <= '0;
		end else begin
			if (clr) begin
				score_q <= '0;
			end else if (adv && prev.valid && active) begin
				// the last subject base leaves a clean column behind it
				score_q <= prev.last ? '0 : h;
			end
			if (adv) begin
				next_q.valid <= prev.valid;
				next_q.base  <= prev.base;
				next_q.last  <= prev.last;
				next_q.h     <= active ? h : '0;
				next_q.diag  <= score_q;
				next_q.best  <= best_n;
			end
		end
	end

	assign next = next_q;

endmodule
